// ----- hdl/bmp24_stream_writer_defines.svh -----
// Assertion macros for the BMP stream writer.
// Included by the top level; depends on nothing else.
`ifndef BMP24_STREAM_WRITER_DEFINES_SVH
`define BMP24_STREAM_WRITER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BSW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsw assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsw assertion failed");

`endif

// ----- hdl/bsw_pkg.sv -----
// Shared types, constants and the header byte table of the BMP stream writer.
// Used by every module of the block; depends on nothing.
package bsw_pkg;

   // Default width of the image dimension registers.
   localparam int DIM_BITS_DEFAULT = 12;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Command queue between front and back.
   localparam int CMD_DEPTH    = 2;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

   // Header layout.
   localparam int HDR_LEN      = 54;
   localparam int HDR_CNT_BITS = $clog2(HDR_LEN);
   localparam logic [HDR_CNT_BITS-1:0] HDR_LAST       = 6'(HDR_LEN - 1);
   localparam logic [HDR_CNT_BITS-1:0] HDR_MAGIC0_POS = 6'd0;
   localparam logic [HDR_CNT_BITS-1:0] HDR_MAGIC1_POS = 6'd1;
   localparam logic [HDR_CNT_BITS-1:0] HDR_SIZE_POS   = 6'd2;
   localparam logic [HDR_CNT_BITS-1:0] HDR_OFFSET_POS = 6'd10;
   localparam logic [HDR_CNT_BITS-1:0] HDR_INFO_POS   = 6'd14;
   localparam logic [HDR_CNT_BITS-1:0] HDR_WIDTH_POS  = 6'd18;
   localparam logic [HDR_CNT_BITS-1:0] HDR_HEIGHT_POS = 6'd22;
   localparam logic [HDR_CNT_BITS-1:0] HDR_PLANES_POS = 6'd26;
   localparam logic [HDR_CNT_BITS-1:0] HDR_BPP_POS    = 6'd28;

   localparam logic [7:0]  MAGIC_B      = 8'h42;
   localparam logic [7:0]  MAGIC_M      = 8'h4D;
   localparam logic [31:0] DATA_OFFSET  = 32'd54;
   localparam logic [7:0]  INFO_SIZE    = 8'd40;
   localparam logic [7:0]  PLANES       = 8'd1;
   localparam logic [7:0]  BITS_PER_PIX = 8'd24;

   // Last pixel byte index; the pixel phase counts 0 to this.
   localparam logic [HDR_CNT_BITS-1:0] PIX_LAST = 6'd2;

   // One queued pixel and what the front decided about it.
   typedef struct packed {
      logic        hdr;        // header goes out before this pixel
      logic [1:0]  pad;        // zero bytes after it (0 when not a row end)
      logic        image_end;  // last pixel of the image
      logic [23:0] pixel;
   } cmd_type;

   // Header byte at a position, all multi-byte fields little-endian.
   function automatic logic [7:0] hdr_byte(input logic [HDR_CNT_BITS-1:0] idx,
                                           input logic [31:0] size,
                                           input logic [31:0] width,
                                           input logic [31:0] height);
      logic [7:0] b;
      b = 8'h00;
      unique case (idx)
         HDR_MAGIC0_POS:          b = MAGIC_B;
         HDR_MAGIC1_POS:          b = MAGIC_M;
         HDR_SIZE_POS:            b = size[7:0];
         HDR_SIZE_POS + 6'd1:     b = size[15:8];
         HDR_SIZE_POS + 6'd2:     b = size[23:16];
         HDR_SIZE_POS + 6'd3:     b = size[31:24];
         HDR_OFFSET_POS:          b = DATA_OFFSET[7:0];
         HDR_INFO_POS:            b = INFO_SIZE;
         HDR_WIDTH_POS:           b = width[7:0];
         HDR_WIDTH_POS + 6'd1:    b = width[15:8];
         HDR_WIDTH_POS + 6'd2:    b = width[23:16];
         HDR_WIDTH_POS + 6'd3:    b = width[31:24];
         HDR_HEIGHT_POS:          b = height[7:0];
         HDR_HEIGHT_POS + 6'd1:   b = height[15:8];
         HDR_HEIGHT_POS + 6'd2:   b = height[23:16];
         HDR_HEIGHT_POS + 6'd3:   b = height[31:24];
         HDR_PLANES_POS:          b = PLANES;
         HDR_BPP_POS:             b = BITS_PER_PIX;
         default:                 b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- hdl/bmp24_stream_writer.sv -----
// Top level of the 24-bit BMP stream writer: front end, command queue, back end.
// Depends on bsw_pkg, bsw_front, bsw_cmd_queue, bsw_back and the defines header.
//
// Usage: pixels (red 23..16, green 15..8, blue 7..0) go in on the req_ queue
// port, one beat per pixel, in row order. Bytes of the BMP file come out on the
// rsp_ queue port, one beat per byte. Before the first pixel of each image the
// 54-byte header goes out; each pixel gives bytes B, G, R; a row end adds
// image_width mod 4 zero bytes. rsp_last_of_run marks the last byte caused by
// a pixel, rsp_end_of_image the last byte of the file.
// Image width and height are written on the csr_ port (index 0 and 1) while
// the block is idle; both reset to 1.
// A pixel passes through the command queue, the back end's command register and the
// output register before its first byte (the first header byte when a header is
// due) shows. Throughput is set by the byte-wide output register: one byte per
// cycle while the receiver pops, so three bytes per pixel, plus the 54 header bytes
// and up to 3 padding bytes per row end. A two-entry command queue lets pixels
// be accepted while bytes of earlier ones are still going out.
// Reset is synchronous and empties the queue and the output register.
// When the receiver stops popping, the output byte holds, the queue fills and
// req_full rises; nothing is lost.
`include "bmp24_stream_writer_defines.svh"

module bmp24_stream_writer #(
   parameter int DIM_BITS = bsw_pkg::DIM_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [23:0]                         req_pixel_color,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last_of_run,
   output logic                                rsp_end_of_image,
   input  logic                                csr_wr_en,
   input  logic [bsw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [DIM_BITS-1:0]                 csr_wr_data
);

   bsw_pkg::cmd_type      cmd;
   bsw_pkg::cmd_type      head;
   logic                  cmd_push;
   logic                  queue_pop;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  back_busy;
   logic [DIM_BITS-1:0]   image_width;
   logic [DIM_BITS-1:0]   image_height;

   assign req_full = queue_full;

   // Front end: registers, counters and classification.
   bsw_front #(
      .DIM_BITS(DIM_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_push       (req_push),
      .req_pixel_color(req_pixel_color),
      .queue_full     (queue_full),
      .cmd_push       (cmd_push),
      .cmd            (cmd),
      .image_width    (image_width),
      .image_height   (image_height)
   );

   // Command queue.
   bsw_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(cmd),
      .pop     (queue_pop),
      .head    (head),
      .full    (queue_full),
      .empty   (queue_empty)
   );

   // Back end: byte sequencer and output register.
   bsw_back #(
      .DIM_BITS(DIM_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .queue_empty     (queue_empty),
      .queue_pop       (queue_pop),
      .image_width     (image_width),
      .image_height    (image_height),
      .busy            (back_busy),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_image(rsp_end_of_image)
   );

   // The end of the file is always the end of a pixel's run.
   `BSW_ASSERT_NOW(a_eoi_is_last, clock, reset, !rsp_empty && rsp_end_of_image, rsp_last_of_run)

   // An idle back end picks up a waiting command at once.
   `BSW_ASSERT_NEXT(a_back_picks_up, clock, reset, !back_busy && !queue_empty, back_busy)

   // The back end only pulls from the queue when it holds something.
   `BSW_ASSERT_NOW(a_no_pop_empty, clock, reset, queue_pop, !queue_empty)

endmodule

// ----- hdl/bsw_front.sv -----
// Front end: configuration registers, row and image counters, pixel classification.
// Depends on bsw_pkg.
module bsw_front #(
   parameter int DIM_BITS = bsw_pkg::DIM_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bsw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [DIM_BITS-1:0]                 csr_wr_data,
   input  logic                                req_push,
   input  logic [23:0]                         req_pixel_color,
   input  logic                                queue_full,
   output logic                                cmd_push,
   output bsw_pkg::cmd_type                    cmd,
   output logic [DIM_BITS-1:0]                 image_width,
   output logic [DIM_BITS-1:0]                 image_height
);

   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic                header_done_ff, header_done_in;
   logic [DIM_BITS:0]   col_next;
   logic [DIM_BITS:0]   row_next;
   logic                accept;
   logic                row_end;
   logic                image_end;

   // Register writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bsw_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wr_data;
            bsw_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Row and image end decisions for the beat on the input.
   assign accept    = req_push && !queue_full;
   assign col_next  = {1'b0, col_ff} + {{DIM_BITS{1'b0}}, 1'b1};
   assign row_next  = {1'b0, row_ff} + {{DIM_BITS{1'b0}}, 1'b1};
   assign row_end   = col_next >= {1'b0, width_ff};
   assign image_end = row_end && (row_next >= {1'b0, height_ff});

   // Counter updates on each accepted pixel.
   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      header_done_in = header_done_ff;
      if (accept) begin
         header_done_in = 1'b1;
         if (row_end) begin
            col_in = '0;
            if (image_end) begin
               row_in         = '0;
               header_done_in = 1'b0;
            end else begin
               row_in = row_next[DIM_BITS-1:0];
            end
         end else begin
            col_in = col_next[DIM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= {{(DIM_BITS-1){1'b0}}, 1'b1};
         height_ff      <= {{(DIM_BITS-1){1'b0}}, 1'b1};
         col_ff         <= '0;
         row_ff         <= '0;
         header_done_ff <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         header_done_ff <= header_done_in;
      end
   end

   // Command toward the back end.
   assign cmd_push       = accept;
   assign cmd.hdr        = !header_done_ff;
   assign cmd.pad        = row_end ? width_ff[1:0] : 2'd0;
   assign cmd.image_end  = image_end;
   assign cmd.pixel      = req_pixel_color;
   assign image_width    = width_ff;
   assign image_height   = height_ff;

endmodule

// ----- hdl/bsw_cmd_queue.sv -----
// Short command queue between the front and back ends.
// Depends on bsw_pkg.
module bsw_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bsw_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output bsw_pkg::cmd_type  head,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = bsw_pkg::CMD_PTR_BITS;
   localparam int CNT_W = bsw_pkg::CMD_CNT_BITS;

   bsw_pkg::cmd_type        entry_ff [bsw_pkg::CMD_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   assign full  = count_ff == CNT_W'(bsw_pkg::CMD_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and fill updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/bsw_back.sv -----
// Back end: byte sequencer for header, pixel and padding bytes, plus the output register.
// Depends on bsw_pkg.
module bsw_back #(
   parameter int DIM_BITS = bsw_pkg::DIM_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bsw_pkg::cmd_type     head,
   input  logic                 queue_empty,
   output logic                 queue_pop,
   input  logic [DIM_BITS-1:0]  image_width,
   input  logic [DIM_BITS-1:0]  image_height,
   output logic                 busy,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run,
   output logic                 rsp_end_of_image
);

   localparam int CNT_W = bsw_pkg::HDR_CNT_BITS;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_HEADER = 4'b0010,
      ST_PIXEL  = 4'b0100,
      ST_PAD    = 4'b1000
   } back_state_type;

   back_state_type             state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   bsw_pkg::cmd_type           cmd_ff, cmd_in;
   logic [31:0]                size_ff, size_in;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_eoi_ff, out_eoi_in;
   logic [DIM_BITS+1:0]        row_bytes;
   logic [2*DIM_BITS+1:0]      prod;
   logic [7:0]                 cur_byte;
   logic                       cur_last;
   logic                       step;
   logic                       done;
   logic                       load;

   // Bytes of one padded row and the pixel data size.
   assign row_bytes = ({2'b00, image_width} << 1) + {2'b00, image_width}
                      + {{DIM_BITS{1'b0}}, image_width[1:0]};
   assign prod      = row_bytes * image_height;

   // Byte of the current position.
   always_comb begin
      cur_byte = 8'h00;
      cur_last = 1'b0;
      unique case (state_ff)
         ST_HEADER: begin
            cur_byte = bsw_pkg::hdr_byte(cnt_ff, size_ff, 32'(image_width),
                                         32'(image_height));
         end
         ST_PIXEL: begin
            unique case (cnt_ff[1:0])
               2'd0:    cur_byte = cmd_ff.pixel[7:0];
               2'd1:    cur_byte = cmd_ff.pixel[15:8];
               default: cur_byte = cmd_ff.pixel[23:16];
            endcase
            cur_last = (cnt_ff == bsw_pkg::PIX_LAST) && (cmd_ff.pad == 2'd0);
         end
         ST_PAD: begin
            cur_last = cnt_ff[1:0] == (cmd_ff.pad - 2'd1);
         end
         default: ;
      endcase
   end

   // Handshake between the sequencer and the output register.
   assign step      = (state_ff != ST_IDLE) && (!out_valid_ff || rsp_pop);
   assign done      = step && cur_last;
   assign load      = !queue_empty && ((state_ff == ST_IDLE) || done);
   assign queue_pop = load;
   assign busy      = state_ff != ST_IDLE;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      if (load) begin
         cmd_in   = head;
         cnt_in   = '0;
         state_in = head.hdr ? ST_HEADER : ST_PIXEL;
      end else if (done) begin
         state_in = ST_IDLE;
      end else if (step) begin
         unique case (state_ff)
            ST_HEADER: begin
               if (cnt_ff == bsw_pkg::HDR_LAST) begin
                  state_in = ST_PIXEL;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            ST_PIXEL: begin
               if (cnt_ff == bsw_pkg::PIX_LAST) begin
                  state_in = ST_PAD;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            default: cnt_in = cnt_ff + CNT_W'(1);
         endcase
      end
   end

   // File size: product while on the first header byte, offset added on the second.
   always_comb begin
      size_in = size_ff;
      if (state_ff == ST_HEADER) begin
         if (cnt_ff == bsw_pkg::HDR_MAGIC0_POS) begin
            size_in = 32'(prod);
         end else if (step && (cnt_ff == bsw_pkg::HDR_MAGIC1_POS)) begin
            size_in = size_ff + bsw_pkg::DATA_OFFSET;
         end
      end
   end

   // Output register, refilled on the cycle its beat is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_eoi_in   = out_eoi_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = cur_last;
         out_eoi_in   = cur_last && cmd_ff.image_end;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      cmd_ff      <= cmd_in;
      size_ff     <= size_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_eoi_ff  <= out_eoi_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_end_of_image = out_eoi_ff;

endmodule

// ----- bench/bmp_stream_sb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard class for the BMP stream writer bench: predicts the file bytes for each pixel beat.
// Depends on bsw_pkg for register indexes, header constants and the dimension width.
package bmp_stream_sb_pkg;
   import bsw_pkg::*;

   localparam int DIM = DIM_BITS_DEFAULT;

   // One byte of the file stream as it should leave the block.
   typedef struct {
      logic [7:0] data;
      logic       last_of_run;
      logic       end_of_image;
   } file_byte_type;

   class bmp_stream_tracker;
      logic [DIM-1:0] width_reg;
      logic [DIM-1:0] height_reg;
      logic [DIM-1:0] col_count;
      logic [DIM-1:0] row_count;
      bit             header_sent;
      file_byte_type  expected_bytes [$];
      int             mismatches;
      int             bytes_seen;

      function new();
         width_reg   = 1;
         height_reg  = 1;
         col_count   = '0;
         row_count   = '0;
         header_sent = 1'b0;
         mismatches  = 0;
         bytes_seen  = 0;
      endfunction

      // A register write takes effect for the next pixel beat.
      function void write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [DIM-1:0] value);
         if (idx == CSR_IMAGE_WIDTH)
            width_reg = value;
         else if (idx == CSR_IMAGE_HEIGHT)
            height_reg = value;
      endfunction

      // Work out every byte one accepted pixel causes and queue them in order.
      function void take_pixel(input logic [23:0] px);
         logic [7:0]    hdr [HDR_LEN];
         logic [31:0]   w32;
         logic [31:0]   h32;
         logic [31:0]   row_bytes;
         logic [31:0]   file_size;
         file_byte_type run [$];
         bit            image_done;
         int            k;
         image_done = 1'b0;

         // The header uses the register values that hold right now.
         if (!header_sent) begin
            w32       = 32'(width_reg);
            h32       = 32'(height_reg);
            row_bytes = 32'd3 * w32 + (w32 & 32'd3);
            file_size = DATA_OFFSET + h32 * row_bytes;
            foreach (hdr[i])
               hdr[i] = 8'h00;
            hdr[HDR_MAGIC0_POS] = MAGIC_B;
            hdr[HDR_MAGIC1_POS] = MAGIC_M;
            hdr[HDR_OFFSET_POS] = DATA_OFFSET[7:0];
            hdr[HDR_INFO_POS]   = INFO_SIZE;
            hdr[HDR_PLANES_POS] = PLANES;
            hdr[HDR_BPP_POS]    = BITS_PER_PIX;
            for (k = 0; k < 4; k++) begin
               hdr[HDR_SIZE_POS + k]   = file_size[8*k +: 8];
               hdr[HDR_WIDTH_POS + k]  = w32[8*k +: 8];
               hdr[HDR_HEIGHT_POS + k] = h32[8*k +: 8];
            end
            foreach (hdr[i])
               run.push_back('{hdr[i], 1'b0, 1'b0});
            header_sent = 1'b1;
         end

         // Pixel goes out blue first.
         run.push_back('{px[7:0], 1'b0, 1'b0});
         run.push_back('{px[15:8], 1'b0, 1'b0});
         run.push_back('{px[23:16], 1'b0, 1'b0});

         // Row end pads to a multiple of four; a zero register ends a row every pixel.
         if (32'(col_count) + 32'd1 >= 32'(width_reg)) begin
            repeat (width_reg[1:0])
               run.push_back('{8'h00, 1'b0, 1'b0});
            col_count = '0;
            if (32'(row_count) + 32'd1 >= 32'(height_reg)) begin
               row_count   = '0;
               header_sent = 1'b0;
               image_done  = 1'b1;
            end else begin
               row_count = row_count + 1'b1;
            end
         end else begin
            col_count = col_count + 1'b1;
         end

         run[run.size()-1].last_of_run  = 1'b1;
         run[run.size()-1].end_of_image = image_done;
         foreach (run[i])
            expected_bytes.push_back(run[i]);
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // One line per mismatch.
      task report_mismatch(input string msg);
         mismatches++;
         $display("MISMATCH at byte %0d: %s", bytes_seen, msg);
      endtask

      // Compare one output beat with the oldest expected byte.
      task check_byte(input logic [7:0] got, input logic got_last, input logic got_end);
         file_byte_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %02h arrived with nothing pending", got));
            bytes_seen++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got !== want.data)
            report_mismatch($sformatf("data %02h, wanted %02h", got, want.data));
         if (got_last !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, wanted %b", got_last, want.last_of_run));
         if (got_end !== want.end_of_image)
            report_mismatch($sformatf("end_of_image %b, wanted %b", got_end, want.end_of_image));
         bytes_seen++;
      endtask
   endclass

endpackage

// ----- bench/tb_bmp24_stream_writer.sv -----
`timescale 1ns / 100ps
// Top of the BMP stream writer bench: clock, reset, pixel sender, byte receiver and monitor.
// Depends on bsw_pkg, bmp_stream_sb_pkg and the bmp24_stream_writer RTL.
module tb_bmp24_stream_writer;
   import bsw_pkg::*;
   import bmp_stream_sb_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_PIXELS = 280;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;
   localparam int LONG_HOLD     = 300;

   typedef enum int {
      POP_EVERY_CYCLE,
      POP_COIN_FLIP,
      POP_THREE_OF_FIVE,
      POP_RARE_STALL
   } pop_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [23:0]               req_pixel_color = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [7:0]                rsp_out_byte;
   logic                      rsp_last_of_run;
   logic                      rsp_end_of_image;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [DIM-1:0]            csr_wr_data = '0;

   bmp_stream_tracker tracker = new();

   // Sender and receiver pacing state.
   int           burst_left = 0;
   bit           gaps_on = 1'b1;
   bit           long_hold_req = 1'b0;
   int           hold_left = 0;
   pop_mode_type pop_mode = POP_EVERY_CYCLE;
   int           mode_left = 0;
   int           pattern_cnt = 0;
   logic         pop_next;
   int           idle_cycles = 0;
   bit           moved;

   always #10 clock = ~clock;

   bmp24_stream_writer #(.DIM_BITS(DIM)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_color  (req_pixel_color),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_image (rsp_end_of_image),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // Monitor: register writes, accepted pixel beats and byte beats, plus the idle watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (csr_wr_en)
            tracker.write_reg(csr_index, csr_wr_data);
         if (req_push && !req_full) begin
            tracker.take_pixel(req_pixel_color);
            moved = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            tracker.check_byte(rsp_out_byte, rsp_last_of_run, rsp_end_of_image);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Receiver: switches between stall patterns, and holds off completely on request.
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_left     = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (mode_left == 0) begin
         pop_mode  = pop_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      pattern_cnt++;
      if (hold_left > 0) begin
         hold_left--;
         pop_next = 1'b0;
      end else begin
         case (pop_mode)
            POP_EVERY_CYCLE:   pop_next = 1'b1;
            POP_COIN_FLIP:     pop_next = 1'($urandom_range(0, 1));
            POP_THREE_OF_FIVE: pop_next = (pattern_cnt % 5) < 3;
            default:           pop_next = $urandom_range(0, 7) != 0;
         endcase
      end
      rsp_pop <= pop_next;
   end

   // Offer one pixel beat and wait for it to be taken; returns at a falling edge.
   // Between bursts the push line drops for a random gap.
   task automatic send_pixel(input logic [23:0] px);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0)
         burst_left--;
      req_push        <= 1'b1;
      req_pixel_color <= px;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic send_random_pixels(input int count);
      repeat (count)
         send_pixel(24'($urandom()));
   endtask

   // Stop offering, wait for every pending byte, then let the pipeline settle.
   task automatic drain_and_settle(input int settle);
      req_push <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Write both dimension registers on back-to-back cycles.
   task automatic set_image(input logic [DIM-1:0] w, input logic [DIM-1:0] h);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_IMAGE_WIDTH;
      csr_wr_data <= w;
      @(negedge clock);
      csr_index   <= CSR_IMAGE_HEIGHT;
      csr_wr_data <= h;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int             sent;
      int             count;
      int             pick;
      logic [DIM-1:0] w;
      logic [DIM-1:0] h;
      sent = 0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset dimensions: every pixel is a whole one-pixel image.
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h5AA5C3);
      drain_and_settle(SETTLE_CYCLES);

      // Zero dimensions: rows and images end on every pixel, no padding.
      set_image('0, '0);
      send_pixel(24'h123456);
      send_pixel(24'hA5A5A5);
      drain_and_settle(SETTLE_CYCLES);

      // Largest dimensions: the header carries the largest width and height; the image stays open.
      set_image('1, '1);
      send_pixel(24'h800001);
      send_pixel(24'h7FFFFE);
      send_pixel(24'hFF00FF);
      drain_and_settle(SETTLE_CYCLES);

      // Shrink the width while the column count is past it: the row ends at once.
      set_image(3, 2);
      send_random_pixels(5);
      drain_and_settle(SETTLE_CYCLES);

      // Widths that need no padding and two bytes of padding.
      set_image(4, 1);
      send_random_pixels(4);
      drain_and_settle(SETTLE_CYCLES);
      set_image(6, 1);
      send_random_pixels(6);
      drain_and_settle(SETTLE_CYCLES);

      // Receiver holds off for a long stretch while pixels keep coming.
      set_image(2, 2);
      long_hold_req = 1'b1;
      gaps_on       = 1'b0;
      send_random_pixels(16);
      gaps_on = 1'b1;
      drain_and_settle(SETTLE_CYCLES);

      // Random phases, mostly whole images of small size.
      while (sent < RANDOM_PIXELS) begin
         pick    = $urandom_range(0, 9);
         gaps_on = $urandom_range(0, 3) != 0;
         if (pick < 7) begin
            w     = DIM'($urandom_range(1, 8));
            h     = DIM'($urandom_range(1, 4));
            count = int'(w) * int'(h) * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0)
               count += $urandom_range(1, int'(w));
         end else if (pick == 7) begin
            w     = DIM'($urandom_range(9, 64));
            h     = 1;
            count = int'(w);
         end else if (pick == 8) begin
            w     = DIM'($urandom_range(0, 1));
            h     = DIM'($urandom_range(0, 1));
            count = $urandom_range(1, 4);
         end else begin
            w     = DIM'($urandom_range(1, 4095));
            h     = DIM'($urandom_range(1, 4095));
            count = $urandom_range(1, 6);
         end
         set_image(w, h);
         send_random_pixels(count);
         sent += count;
         drain_and_settle(SETTLE_CYCLES);
      end

      drain_and_settle(END_CYCLES);
      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
